FILE: rtl/core/cs_pkg.sv
package cs_pkg;

   localparam int KEY_PORT_W = 8;
   localparam int IDX_PORT_W = 6;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_INC  = 3'd1,
      OP_ACC  = 3'd2,
      OP_DEC  = 3'd3,
      OP_CLR  = 3'd4
   } cnt_op_type;

   typedef struct packed {
      cnt_op_type op;
      logic       run_clr;
   } cnt_ctrl_type;

endpackage

FILE: rtl/core/cs_count_unit.sv
module cs_count_unit
   import cs_pkg::*;
#(
   parameter int KEY_BITS = 8,
   parameter int CNT_BITS = 7
) (
   input  logic                clock,
   input  cnt_ctrl_type        ctrl,
   input  logic [KEY_BITS-1:0] raddr,
   input  logic [KEY_BITS-1:0] waddr,
   output logic [CNT_BITS-1:0] rdata
);

   localparam int DEPTH = 2 ** KEY_BITS;

   logic [CNT_BITS-1:0] mem [DEPTH];
   logic [CNT_BITS-1:0] rdata_ff;
   logic [CNT_BITS-1:0] run_ff;
   logic [CNT_BITS-1:0] run_in;
   logic [CNT_BITS-1:0] wdata;
   logic                wen;

   // count update: increment, running sum, decrement or clear; no write otherwise
   always_comb begin
      run_in = run_ff;
      wdata  = '0;
      wen    = 1'b1;
      case (ctrl.op)
         OP_INC: begin
            wdata = rdata_ff + 1'b1;
         end
         OP_ACC: begin
            run_in = run_ff + rdata_ff;
            wdata  = run_in;
         end
         OP_DEC: begin
            wdata = rdata_ff - 1'b1;
         end
         OP_CLR: begin
            wdata = '0;
         end
         default: begin
            wen = 1'b0;
         end
      endcase
      if (ctrl.run_clr) begin
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
      run_ff   <= run_in;
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/counting_sort_stable.sv
// loading: a stored key passes S_IDLE and S_INC, a dropped key stays in S_IDLE; after the
// last transaction the prefix scan runs over keys min..max, then placement takes each key
// through S_P_KEY, S_P_CNT and S_P_WR via the count store's single read port, then S_E_RD
// and, per result, S_E_LD and S_E_WAIT until rsp ready; one set at a time; after the final
// result a pass over min..max zeroes counts; reset: synchronous, a clearing pass over every key
// zeroes the count store while req_tready stays low
module counting_sort_stable
   import cs_pkg::*;
#(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[7:0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // sorted_key[7:0], source_index[13:8], zero pad
   output logic                  rsp_tuser,   // overflow
   output logic                  rsp_tlast
);

   localparam int IDXW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNTW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b00000000001,
      S_IDLE     = 11'b00000000010,
      S_INC      = 11'b00000000100,
      S_SCAN     = 11'b00000001000,
      S_SCAN_END = 11'b00000010000,
      S_P_KEY    = 11'b00000100000,
      S_P_CNT    = 11'b00001000000,
      S_P_WR     = 11'b00010000000,
      S_E_RD     = 11'b00100000000,
      S_E_LD     = 11'b01000000000,
      S_E_WAIT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] min_ff, min_in;
   logic [KEY_BITS-1:0] max_ff, max_in;
   logic                ovf_ff, ovf_in;
   logic                last_ff, last_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] v_ff, v_in;
   logic [KEY_BITS-1:0] vd_ff, vd_in;
   logic [KEY_BITS-1:0] hi_ff, hi_in;
   logic                pend_ff, pend_in;
   logic [IDXW-1:0]     pos_ff, pos_in;
   logic [IDXW-1:0]     eidx_ff, eidx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [IDXW-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [KEY_BITS-1:0]      kbuf_mem [MAX_ITEMS];
   logic [KEY_BITS-1:0]      kb_rdata_ff;
   logic [KEY_BITS+IDXW-1:0] rbuf_mem [MAX_ITEMS];
   logic [KEY_BITS+IDXW-1:0] rb_rdata_ff;

   logic [KEY_BITS-1:0] req_key;
   logic                req_fire;
   logic                rsp_fire;
   logic                room;
   logic                kb_wen;
   logic                rb_wen;
   logic [IDXW-1:0]     rb_waddr;

   cnt_ctrl_type        cnt_ctrl;
   logic [KEY_BITS-1:0] cnt_raddr;
   logic [KEY_BITS-1:0] cnt_waddr;
   logic [CNTW-1:0]     cnt_rdata;

   cs_count_unit #(
      .KEY_BITS (KEY_BITS),
      .CNT_BITS (CNTW)
   ) u_count (
      .clock (clock),
      .ctrl  (cnt_ctrl),
      .raddr (cnt_raddr),
      .waddr (cnt_waddr),
      .rdata (cnt_rdata)
   );

   assign req_key  = KEY_BITS'(req_tdata[KEY_PORT_W-1:0]);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;
   assign room     = (cnt_ff != CNTW'(MAX_ITEMS));
   assign kb_wen   = req_fire && room;
   assign rb_wen   = (state_ff == S_P_WR);
   assign rb_waddr = IDXW'(cnt_rdata - 1'b1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      v_in         = v_ff;
      vd_in        = v_ff;
      hi_in        = hi_ff;
      pend_in      = 1'b0;
      pos_in       = pos_ff;
      eidx_in      = eidx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      cnt_ctrl     = '{op: OP_NONE, run_clr: 1'b0};
      cnt_raddr    = v_ff;
      cnt_waddr    = v_ff;

      case (state_ff)
         S_CLEAR: begin
            cnt_ctrl.op = OP_CLR;
            if (v_ff == hi_ff) begin
               state_in = S_IDLE;
               cnt_in   = '0;
               min_in   = '1;
               max_in   = '0;
               ovf_in   = 1'b0;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         S_IDLE: begin
            cnt_ctrl.run_clr = 1'b1;
            cnt_raddr        = req_key;
            if (req_fire) begin
               last_in = req_tlast;
               key_in  = req_key;
               if (room) begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_INC;
                  if (req_key < min_ff) begin
                     min_in = req_key;
                  end
                  if (req_key > max_ff) begin
                     max_in = req_key;
                  end
               end else begin
                  ovf_in = 1'b1;
                  if (req_tlast) begin
                     state_in = S_SCAN;
                     v_in     = min_ff;
                  end
               end
            end
         end
         S_INC: begin
            cnt_ctrl    = '{op: OP_INC, run_clr: 1'b1};
            cnt_waddr   = key_ff;
            if (last_ff) begin
               state_in = S_SCAN;
               v_in     = min_ff;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            pend_in   = 1'b1;
            cnt_raddr = v_ff;
            cnt_waddr = vd_ff;
            if (pend_ff) begin
               cnt_ctrl.op = OP_ACC;
            end
            if (v_ff == max_ff) begin
               state_in = S_SCAN_END;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         S_SCAN_END: begin
            cnt_ctrl.op = OP_ACC;
            cnt_waddr   = vd_ff;
            state_in    = S_P_KEY;
            pos_in      = IDXW'(cnt_ff - 1'b1);
         end
         S_P_KEY: begin
            state_in = S_P_CNT;
         end
         S_P_CNT: begin
            cnt_raddr = kb_rdata_ff;
            state_in  = S_P_WR;
         end
         S_P_WR: begin
            cnt_ctrl.op = OP_DEC;
            cnt_waddr   = kb_rdata_ff;
            if (pos_ff == '0) begin
               state_in = S_E_RD;
               eidx_in  = '0;
            end else begin
               pos_in   = pos_ff - 1'b1;
               state_in = S_P_KEY;
            end
         end
         S_E_RD: begin
            state_in = S_E_LD;
         end
         S_E_LD: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = rb_rdata_ff[IDXW +: KEY_BITS];
            rsp_idx_in   = rb_rdata_ff[IDXW-1:0];
            rsp_ovf_in   = ovf_ff;
            rsp_last_in  = ((CNTW'(eidx_ff) + 1'b1) == cnt_ff);
            state_in     = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_CLEAR;
                  v_in     = min_ff;
                  hi_in    = max_ff;
               end else begin
                  eidx_in  = eidx_ff + 1'b1;
                  state_in = S_E_LD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         v_ff         <= '0;
         hi_ff        <= '1;
         pend_ff      <= 1'b0;
         pos_ff       <= '0;
         eidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         v_ff         <= v_in;
         hi_ff        <= hi_in;
         pend_ff      <= pend_in;
         pos_ff       <= pos_in;
         eidx_ff      <= eidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      vd_ff       <= vd_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // key buffer and result buffer
   always_ff @(posedge clock) begin
      if (kb_wen) begin
         kbuf_mem[cnt_ff[IDXW-1:0]] <= req_key;
      end
      kb_rdata_ff <= kbuf_mem[pos_ff];
      if (rb_wen) begin
         rbuf_mem[rb_waddr] <= {kb_rdata_ff, pos_ff};
      end
      rb_rdata_ff <= rbuf_mem[eidx_in];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({IDX_PORT_W'(rsp_idx_ff), KEY_PORT_W'(rsp_key_ff)});
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: verif/counting_sort_stable_test.sv
`timescale 1ns / 1ps

module counting_sort_stable_test
   import cs_pkg::*;
();

   localparam int SET_CAP = 64;
   localparam int KEY_W = 8;
   localparam int KEY_SPAN = 1 << KEY_W;
   localparam int RANDOM_ITEMS = 187;
   localparam int TAIL_CYCLES = 600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SCRIPT_LEN = 23;

   typedef struct packed {
      logic [KEY_PORT_W-1:0] key;
      logic [IDX_PORT_W-1:0] idx;
      logic                  ovf;
      logic                  eor;
   } sorted_entry_type;

   typedef struct packed {
      logic [7:0] key;
      logic       last;
      logic       typed;
      logic [7:0] t_key;
      logic [5:0] t_idx;
   } script_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // key[7:0]
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // sorted_key[7:0], source_index[13:8], zero pad
   logic                  rsp_tuser;       // overflow
   logic                  rsp_tlast;
   logic                  steady = 1'b0;

   sorted_entry_type expected_sorted[$];
   int               mismatches = 0;
   int               cycles = 0;

   // predictor state
   logic [KEY_W-1:0] held_key[SET_CAP];
   logic [6:0]       key_tally[KEY_SPAN];
   logic [KEY_W-1:0] placed_key[SET_CAP];
   logic [5:0]       placed_idx[SET_CAP];
   int               fill;
   logic [KEY_W-1:0] lo_key;
   logic [KEY_W-1:0] hi_key;
   logic             dropped;

   script_row_type script[SCRIPT_LEN];

   counting_sort_stable DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic clear_sort_set();
      for (int v = 0; v < KEY_SPAN; v++) key_tally[v] = '0;
      fill = 0;
      lo_key = '1;
      hi_key = '0;
      dropped = 1'b0;
   endtask

   task automatic sort_take(input logic [7:0] key_in, input logic last_in);
      logic [KEY_W-1:0] k;
      logic [6:0]       c;
      int               run;
      int               slot;
      sorted_entry_type e;
      k = key_in[KEY_W-1:0];
      if (fill < SET_CAP) begin
         held_key[fill] = k;
         key_tally[k] = key_tally[k] + 7'd1;
         if (k < lo_key) lo_key = k;
         if (k > hi_key) hi_key = k;
         fill++;
      end else begin
         dropped = 1'b1;
      end
      if (!last_in) return;
      run = 0;
      if (fill > 0) begin
         for (int v = int'(lo_key); v <= int'(hi_key); v++) begin
            run += int'(key_tally[v]);
            key_tally[v] = run[6:0];
         end
      end
      for (int p = fill - 1; p >= 0; p--) begin
         c = key_tally[held_key[p]];
         if (c != 0) begin
            slot = int'(c) - 1;
            if (slot < SET_CAP) begin
               placed_key[slot] = held_key[p];
               placed_idx[slot] = p[5:0];
            end
            key_tally[held_key[p]] = slot[6:0];
         end
      end
      for (int i = 0; i < fill; i++) begin
         e.key = placed_key[i];
         e.idx = placed_idx[i];
         e.ovf = dropped;
         e.eor = (i == fill - 1);
         expected_sorted.push_back(e);
      end
      clear_sort_set();
   endtask

   task automatic report_mismatch(input string what, input sorted_entry_type got,
                                  input sorted_entry_type want);
      $display("mismatch %s: got %0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d (key/idx/ovf/eor)",
               what, got.key, got.idx, got.ovf, got.eor,
               want.key, want.idx, want.ovf, want.eor);
      mismatches++;
   endtask

   task automatic send_key(input logic [7:0] k, input logic l);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= k;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_sorted();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_sorted.size() != 0);
   endtask

   always @(posedge clock) begin
      sorted_entry_type got;
      sorted_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.key = rsp_tdata[KEY_PORT_W-1:0];
         got.idx = rsp_tdata[KEY_PORT_W +: IDX_PORT_W];
         got.ovf = rsp_tuser;
         got.eor = rsp_tlast;
         if (expected_sorted.size() == 0) begin
            report_mismatch("unexpected transaction", got, got);
         end else begin
            want = expected_sorted.pop_front();
            if (got != want) report_mismatch("field", got, want);
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int               mark;
      int               sent;
      int               set_no;
      int               set_len;
      logic             narrow;
      logic [7:0]       base;
      logic [7:0]       k;
      logic             l;
      sorted_entry_type typed_e;

      script = '{
         '{8'd0,   1'b1, 1'b1, 8'd0,   6'd0},
         '{8'd255, 1'b1, 1'b1, 8'd255, 6'd0},
         '{8'd5,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd3,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd5,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd3,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd0,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd255, 1'b1, 1'b0, 8'd0,   6'd0},
         '{8'd7,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd7,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd7,   1'b1, 1'b0, 8'd0,   6'd0},
         '{8'd200, 1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd100, 1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd50,  1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd1,   1'b1, 1'b0, 8'd0,   6'd0},
         '{8'd128, 1'b1, 1'b1, 8'd128, 6'd0},
         '{8'd1,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd2,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd4,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd8,   1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd16,  1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd32,  1'b0, 1'b0, 8'd0,   6'd0},
         '{8'd64,  1'b1, 1'b0, 8'd0,   6'd0}
      };
      clear_sort_set();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed sets
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         send_key(script[r].key, script[r].last);
         mark = expected_sorted.size();
         sort_take(script[r].key, script[r].last);
         if (script[r].typed) begin
            while (expected_sorted.size() > mark) void'(expected_sorted.pop_back());
            typed_e.key = script[r].t_key;
            typed_e.idx = script[r].t_idx;
            typed_e.ovf = 1'b0;
            typed_e.eor = 1'b1;
            expected_sorted.push_back(typed_e);
         end
      end

      // random sets: mostly small, one full, one past capacity
      sent = 0;
      set_no = 0;
      while (sent < RANDOM_ITEMS) begin
         if (set_no == 3 || set_no == 6) drain_sorted();
         steady <= (set_no >= 8 && set_no <= 12);
         case (set_no)
            2: begin
               set_len = SET_CAP;
            end
            4: begin
               set_len = SET_CAP + $urandom_range(1, 3);
            end
            default: begin
               set_len = $urandom_range(1, 8);
            end
         endcase
         narrow = ($urandom_range(0, 2) == 0);
         base = 8'($urandom_range(0, 255));
         for (int i = 0; i < set_len; i++) begin
            if (narrow) k = base + 8'($urandom_range(0, 3));
            else k = 8'($urandom_range(0, 255));
            l = (i == set_len - 1);
            send_key(k, l);
            sort_take(k, l);
            sent++;
         end
         set_no++;
      end
      steady <= 1'b0;

      drain_sorted();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/cs_pkg.sv
rtl/core/cs_count_unit.sv
rtl/core/counting_sort_stable.sv
verif/counting_sort_stable_test.sv
